// ===== hw/rtl/vll_pkg.sv =====
// Package for the vertex Lambert lighting block.
// Types, register codes and pipeline depth constants; no dependencies.
package vll_pkg;

  localparam int RECIP_STEPS = 33;
  localparam int LIGHT_LAT   = 4;
  localparam int INTEN_DLY   = RECIP_STEPS - LIGHT_LAT;

  localparam logic [14:0]        ONE_Q14 = 15'd16384;
  localparam logic signed [31:0] INV_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [2:0] {
    REG_LIGHT_X  = 3'd0,
    REG_LIGHT_Y  = 3'd1,
    REG_LIGHT_Z  = 3'd2,
    REG_GAIN     = 3'd3,
    REG_AMBIENT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic [15:0]        diffuse_gain;
    logic [14:0]        ambient_level;
  } light_cfg_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic tiny;
  } recip_flags_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
    logic        valid;
  } side_t;

endpackage

// ===== hw/rtl/vll_if.sv =====
// Stream interfaces for the vertex Lambert lighting block.
// Vertex input word and lit result word; no dependencies.
interface vll_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic               end_of_list;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, end_of_list,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, end_of_list,
                  output ready);
endinterface

interface vll_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] inv_depth;
  logic [14:0]        intensity;
  logic               depth_saturated;
  logic               last_out;

  modport source (output valid, out_x, out_y, inv_depth, intensity, depth_saturated,
                  last_out, input ready);
  modport sink   (input valid, out_x, out_y, inv_depth, intensity, depth_saturated,
                  last_out, output ready);
endinterface

// ===== hw/rtl/vll_light.sv =====
// Lambert diffuse plus ambient intensity, four register stages.
// Depends on vll_pkg.
module vll_light import vll_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  light_cfg_t         cfg,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  output logic [14:0]        intensity
);

  logic signed [31:0] p0;
  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic signed [33:0] ndot;
  logic signed [50:0] lit;
  logic [22:0]        lit_q;
  logic [23:0]        sum;
  logic [14:0]        inten_next;
  logic [14:0]        inten;

  always_ff @(posedge clk) begin
    if (en) begin
      p0    <= cfg.light_x * norm_x;
      p1    <= cfg.light_y * norm_y;
      p2    <= cfg.light_z * norm_z;
      ndot  <= -(34'(p0) + 34'(p1) + 34'(p2));
      lit   <= ndot * $signed({1'b0, cfg.diffuse_gain});
      inten <= inten_next;
    end
  end

  // clamp at zero, drop 28 fraction bits, add ambient, clamp at one
  always_comb begin
    lit_q      = lit[50] ? '0 : lit[50:28];
    sum        = 24'(lit_q) + 24'(cfg.ambient_level);
    inten_next = (sum > 24'(ONE_Q14)) ? ONE_Q14 : sum[14:0];
  end

  assign intensity = inten;

endmodule

// ===== hw/rtl/vll_recip.sv =====
// Pipelined restoring divider for 2^32 / |z|, one quotient bit per stage.
// Depends on vll_pkg.
module vll_recip import vll_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [31:0]            den,
  input  recip_flags_t           flags_in,
  output logic [RECIP_STEPS-1:0] quo,
  output recip_flags_t           flags_out
);

  logic [31:0]            rem   [1:RECIP_STEPS-1];
  logic [31:0]            dv    [1:RECIP_STEPS-1];
  logic [RECIP_STEPS-1:0] qa    [1:RECIP_STEPS];
  recip_flags_t           fl    [1:RECIP_STEPS];

  logic [31:0]            src_rem [0:RECIP_STEPS-1];
  logic [31:0]            src_den [0:RECIP_STEPS-1];
  logic [RECIP_STEPS-1:0] src_quo [0:RECIP_STEPS-1];
  recip_flags_t           src_fl  [0:RECIP_STEPS-1];
  logic [32:0]            trial   [0:RECIP_STEPS-1];
  logic [31:0]            rem_next [0:RECIP_STEPS-1];
  logic [RECIP_STEPS-1:0] quo_next [0:RECIP_STEPS-1];

  always_comb begin
    src_rem[0] = '0;
    src_den[0] = den;
    src_quo[0] = '0;
    src_fl[0]  = flags_in;
    for (int i = 1; i < RECIP_STEPS; i++) begin
      src_rem[i] = rem[i];
      src_den[i] = dv[i];
      src_quo[i] = qa[i];
      src_fl[i]  = fl[i];
    end
    // dividend is a single one at the top bit, brought in by the first stage
    for (int i = 0; i < RECIP_STEPS; i++) begin
      trial[i] = {src_rem[i], 1'(i == 0)};
      if (trial[i] >= {1'b0, src_den[i]}) begin
        rem_next[i] = 32'(trial[i] - {1'b0, src_den[i]});
        quo_next[i] = {src_quo[i][RECIP_STEPS-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[i][31:0];
        quo_next[i] = {src_quo[i][RECIP_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 1; i < RECIP_STEPS; i++) begin
        rem[i] <= rem_next[i-1];
        dv[i]  <= src_den[i-1];
      end
      for (int i = 1; i <= RECIP_STEPS; i++) begin
        qa[i] <= quo_next[i-1];
        fl[i] <= src_fl[i-1];
      end
    end
  end

  assign quo       = qa[RECIP_STEPS];
  assign flags_out = fl[RECIP_STEPS];

endmodule

// ===== hw/rtl/vertex_lambert_light.sv =====
// Top level of the vertex Lambert lighting block.
// Depends on vll_pkg, vll_if, vll_light and vll_recip.
//
//   port    dir   word
//   vertex  in    position Q16.16 x/y/z, normal Q2.14 x/y/z, end_of_list
//   result  out   x, y, 1/z Q16.16, intensity Q1.14, depth_saturated, last_out
//   cfg_*   in    write enable, register index, 16-bit data
//
// One vertex per cycle while the output is not stalled; a vertex passes the input register, 33 divider
// stages (one quotient bit each) and the output register.
// Synchronous reset clears the valid bits and loads the register defaults.
// A stall at the output holds the whole pipeline; bubbles drain while the
// output register is empty.
module vertex_lambert_light import vll_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  vll_vertex_if.sink  vertex,
  vll_result_if.source result
);

  light_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_x       <= '0;
      cfg.light_y       <= '0;
      cfg.light_z       <= -16'sd16384;
      cfg.diffuse_gain  <= 16'd16384;
      cfg.ambient_level <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LIGHT_X: cfg.light_x       <= cfg_data;
        REG_LIGHT_Y: cfg.light_y       <= cfg_data;
        REG_LIGHT_Z: cfg.light_z       <= cfg_data;
        REG_GAIN:    cfg.diffuse_gain  <= cfg_data;
        REG_AMBIENT: cfg.ambient_level <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic o_valid;

  assign adv          = !o_valid || result.ready;
  assign vertex.ready = adv;

  // input register
  logic [31:0]        z_mag;
  recip_flags_t       z_flags;
  logic [31:0]        c_mag;
  recip_flags_t       c_flags;
  logic signed [15:0] c_nx;
  logic signed [15:0] c_ny;
  logic signed [15:0] c_nz;
  side_t              side [0:RECIP_STEPS];

  always_comb begin
    z_mag        = vertex.pos_z[31] ? 32'(-vertex.pos_z) : vertex.pos_z;
    z_flags.neg  = vertex.pos_z[31];
    z_flags.zero = (vertex.pos_z == '0);
    z_flags.tiny = (z_mag == 32'd1) || (z_mag == 32'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= RECIP_STEPS; k++) side[k].valid <= 1'b0;
    end else if (adv) begin
      side[0].x     <= vertex.pos_x;
      side[0].y     <= vertex.pos_y;
      side[0].last  <= vertex.end_of_list;
      side[0].valid <= vertex.valid;
      for (int k = 1; k <= RECIP_STEPS; k++) side[k] <= side[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_mag   <= z_mag;
      c_flags <= z_flags;
      c_nx    <= vertex.norm_x;
      c_ny    <= vertex.norm_y;
      c_nz    <= vertex.norm_z;
    end
  end

  // lighting and reciprocal
  logic [14:0]            inten;
  logic [14:0]            inten_d [1:INTEN_DLY];
  logic [RECIP_STEPS-1:0] quo;
  recip_flags_t           q_flags;

  vll_light u_light (
    .clk       (clk),
    .en        (adv),
    .cfg       (cfg),
    .norm_x    (c_nx),
    .norm_y    (c_ny),
    .norm_z    (c_nz),
    .intensity (inten)
  );

  vll_recip u_recip (
    .clk       (clk),
    .en        (adv),
    .den       (c_mag),
    .flags_in  (c_flags),
    .quo       (quo),
    .flags_out (q_flags)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      inten_d[1] <= inten;
      for (int k = 2; k <= INTEN_DLY; k++) inten_d[k] <= inten_d[k-1];
    end
  end

  // sign and saturation, output register
  logic [31:0]        q32;
  logic signed [31:0] inv_next;
  logic               sat_next;

  always_comb begin
    q32 = quo[31:0];
    if (q_flags.zero) begin
      inv_next = INV_MAX;
      sat_next = 1'b1;
    end else if (q_flags.tiny) begin
      inv_next = q_flags.neg ? -INV_MAX : INV_MAX;
      sat_next = 1'b1;
    end else begin
      inv_next = q_flags.neg ? -q32 : q32;
      sat_next = 1'b0;
    end
  end

  logic [31:0] o_x;
  logic [31:0] o_y;
  logic [31:0] o_inv;
  logic [14:0] o_inten;
  logic        o_sat;
  logic        o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= side[RECIP_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_x     <= side[RECIP_STEPS].x;
      o_y     <= side[RECIP_STEPS].y;
      o_last  <= side[RECIP_STEPS].last;
      o_inv   <= inv_next;
      o_sat   <= sat_next;
      o_inten <= inten_d[INTEN_DLY];
    end
  end

  assign result.valid           = o_valid;
  assign result.out_x           = o_x;
  assign result.out_y           = o_y;
  assign result.inv_depth       = o_inv;
  assign result.intensity       = o_inten;
  assign result.depth_saturated = o_sat;
  assign result.last_out        = o_last;

endmodule

// ===== tb/vertex_lambert_light_checker.sv =====
// Checker for vertex_lambert_light: watches the vertex and result channels and
// the register write port, predicts each lit word and compares it field by field.
// Depends on vll_pkg and the stream interfaces in vll_if.
module vertex_lambert_light_checker import vll_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  vll_vertex_if       vertex,
  vll_result_if       result,
  output int          outstanding,
  output int          mismatches,
  output int          lit_count,
  output int          saturated_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] inv;
    logic [14:0] inten;
    logic        sat;
    logic        last;
  } lit_word_t;

  light_cfg_t lighting;
  lit_word_t  lit_q[$];

  function automatic lit_word_t shade_vertex(logic signed [31:0] px, logic signed [31:0] py,
                                             logic signed [31:0] pz, logic signed [15:0] nx,
                                             logic signed [15:0] ny, logic signed [15:0] nz,
                                             logic eol);
    lit_word_t w;
    longint    dot;
    longint    lambert;
    longint    level;
    longint    depth;
    longint    recip;
    dot = longint'(lighting.light_x) * longint'(nx) + longint'(lighting.light_y) * longint'(ny)
        + longint'(lighting.light_z) * longint'(nz);
    lambert = -(dot * longint'(lighting.diffuse_gain));
    if (lambert < 0) lambert = 0;
    level = (lambert >>> 28) + longint'(lighting.ambient_level);
    if (level > longint'(ONE_Q14)) level = longint'(ONE_Q14);
    depth = longint'(pz);
    w.sat = 1'b0;
    if (depth == 0) begin
      recip = longint'(INV_MAX);
      w.sat = 1'b1;
    end else begin
      recip = (longint'(1) <<< 32) / depth;
      if (recip > longint'(INV_MAX)) begin
        recip = longint'(INV_MAX);
        w.sat = 1'b1;
      end else if (recip < -longint'(INV_MAX)) begin
        recip = -longint'(INV_MAX);
        w.sat = 1'b1;
      end
    end
    w.x     = px;
    w.y     = py;
    w.inv   = recip[31:0];
    w.inten = level[14:0];
    w.last  = eol;
    return w;
  endfunction

  function automatic int field_off(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return 0;
    $error("%s: expected %0h, got %0h", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    lit_word_t want;
    int        bad;
    bad = 0;
    if (rst) begin
      lighting <= '{light_x: 16'sd0, light_y: 16'sd0, light_z: -16'sd16384,
                    diffuse_gain: 16'd16384, ambient_level: 15'd0};
      lit_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LIGHT_X: lighting.light_x       <= cfg_data;
          REG_LIGHT_Y: lighting.light_y       <= cfg_data;
          REG_LIGHT_Z: lighting.light_z       <= cfg_data;
          REG_GAIN:    lighting.diffuse_gain  <= cfg_data;
          REG_AMBIENT: lighting.ambient_level <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (lit_q.size() == 0) begin
          $error("result word with no vertex pending");
          bad++;
        end else begin
          want = lit_q.pop_front();
          bad += field_off("out_x", want.x, result.out_x);
          bad += field_off("out_y", want.y, result.out_y);
          bad += field_off("inv_depth", want.inv, result.inv_depth);
          bad += field_off("intensity", 32'(want.inten), 32'(result.intensity));
          bad += field_off("depth_saturated", 32'(want.sat), 32'(result.depth_saturated));
          bad += field_off("last_out", 32'(want.last), 32'(result.last_out));
          if (want.sat) saturated_count <= saturated_count + 1;
        end
        lit_count <= lit_count + 1;
      end
      if (vertex.valid && vertex.ready)
        lit_q.push_back(shade_vertex(vertex.pos_x, vertex.pos_y, vertex.pos_z, vertex.norm_x,
                                     vertex.norm_y, vertex.norm_z, vertex.end_of_list));
    end
    outstanding <= lit_q.size();
    mismatches  <= mismatches + bad;
  end

endmodule

// ===== tb/vertex_lambert_light_tb.sv =====
// Testbench top for vertex_lambert_light: clock, reset, register writes, vertex
// stimulus with random gaps and result back-pressure, watchdog and verdict.
// Depends on vll_pkg, vll_if, the block's RTL and vertex_lambert_light_checker.
module vertex_lambert_light_tb import vll_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CFG_REGS     = 5;
  localparam int N_SETUPS       = 8;
  localparam int SETUP_VERTICES = 104;
  localparam int HOLD_AT        = 450;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               eol;
  } vertex_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  bit          idling;
  int          quiet;
  int          outstanding;
  int          mismatches;
  int          lit_count;
  int          saturated_count;

  vll_vertex_if vertex();
  vll_result_if result();

  vertex_lambert_light dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vertex    (vertex),
    .result    (result)
  );

  vertex_lambert_light_checker lit_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .vertex          (vertex),
    .result          (result),
    .outstanding     (outstanding),
    .mismatches      (mismatches),
    .lit_count       (lit_count),
    .saturated_count (saturated_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic vertex_word_t make_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                               logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                               logic eol);
    vertex_word_t v;
    v = '{px: px, py: py, pz: pz, nx: nx, ny: ny, nz: nz, eol: eol};
    return v;
  endfunction

  function automatic logic [15:0] pick_norm();
    if ($urandom_range(0, 4) != 0) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'sd16384;
      default: return -16'sd16384;
    endcase
  endfunction

  function automatic vertex_word_t random_vertex();
    vertex_word_t v;
    v.px = $urandom;
    v.py = $urandom;
    case ($urandom_range(0, 9))
      0: v.pz = $urandom_range(0, 8) - 4;
      1: v.pz = ($urandom & 32'h0003_FFFF) - 32'h0002_0000;
      default: v.pz = $urandom;
    endcase
    v.nx  = pick_norm();
    v.ny  = pick_norm();
    v.nz  = pick_norm();
    v.eol = ($urandom_range(0, 7) == 0);
    return v;
  endfunction

  // call at a clock edge; returns at the edge that takes the word
  task automatic send_vertex(vertex_word_t v);
    int gap;
    gap = idling ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      vertex.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vertex.valid       <= 1'b1;
    vertex.pos_x       <= v.px;
    vertex.pos_y       <= v.py;
    vertex.pos_z       <= v.pz;
    vertex.norm_x      <= v.nx;
    vertex.norm_y      <= v.ny;
    vertex.norm_z      <= v.nz;
    vertex.end_of_list <= v.eol;
    do @(posedge clk); while (!vertex.ready);
  endtask

  task automatic drain();
    vertex.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic put_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic write_lighting(light_cfg_t c);
    put_reg(REG_LIGHT_X, c.light_x);
    put_reg(REG_LIGHT_Y, c.light_y);
    put_reg(REG_LIGHT_Z, c.light_z);
    put_reg(REG_GAIN, c.diffuse_gain);
    put_reg(REG_AMBIENT, {1'($urandom), c.ambient_level});
    // unmapped indexes must be ignored
    for (int i = N_CFG_REGS; i < (1 << $bits(cfg_index)); i++)
      put_reg(3'(i), 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    light_cfg_t setup;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= 3'd0;
    cfg_data           <= 16'd0;
    vertex.valid       <= 1'b0;
    vertex.pos_x       <= '0;
    vertex.pos_y       <= '0;
    vertex.pos_z       <= '0;
    vertex.norm_x      <= '0;
    vertex.norm_y      <= '0;
    vertex.norm_z      <= '0;
    vertex.end_of_list <= 1'b0;
    idling = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset lighting: light along -z, unit gain, no ambient
    send_vertex(make_vertex(0, 0, 0, 0, 0, 0, 1'b0));
    send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 16384, 1'b1));
    send_vertex(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, -1, 0, 0, -16384, 1'b0));
    send_vertex(make_vertex(-1, 0, 2, 0, 0, 32767, 1'b1));
    send_vertex(make_vertex(0, -1, -2, 0, 0, 16'h8000, 1'b0));
    send_vertex(make_vertex(1, 2, 3, 32767, 32767, 32767, 1'b0));
    send_vertex(make_vertex(3, 4, -3, 16'h8000, 16'h8000, 16'h8000, 1'b1));
    send_vertex(make_vertex(5, 6, 32'h7FFF_FFFF, 0, 0, 8192, 1'b0));
    send_vertex(make_vertex(7, 8, 32'h8000_0000, 0, 0, -8192, 1'b0));
    send_vertex(make_vertex(9, 10, 32'h0001_0000, 16384, 16384, 16384, 1'b0));
    send_vertex(make_vertex(11, 12, 32'hFFFF_0000, -16384, -16384, 1, 1'b1));
    send_vertex(make_vertex(13, 14, 32'h0001_0001, 0, 0, 1, 1'b0));
    send_vertex(make_vertex(15, 16, 4, 0, 0, 16'hFFFF, 1'b0));
    send_vertex(make_vertex(17, 18, -4, 32767, 16'h8000, 0, 1'b1));

    for (int p = 0; p < N_SETUPS; p++) begin
      case (p)
        0: setup = '{light_x: 16'sh7FFF, light_y: 16'sh7FFF, light_z: 16'sh7FFF,
                     diffuse_gain: 16'hFFFF, ambient_level: 15'd0};
        1: setup = '{light_x: 16'sh8000, light_y: 16'sh8000, light_z: 16'sh8000,
                     diffuse_gain: 16'hFFFF, ambient_level: 15'h7FFF};
        2: setup = '{light_x: 16'sd0, light_y: 16'sd0, light_z: 16'sd0,
                     diffuse_gain: 16'd0, ambient_level: 15'd16384};
        3: setup = '{light_x: 16'sd16384, light_y: 16'sd0, light_z: 16'sd0,
                     diffuse_gain: 16'd16384, ambient_level: 15'd8192};
        default: begin
          setup.light_x      = 16'($urandom);
          setup.light_y      = 16'($urandom);
          setup.light_z      = 16'($urandom);
          setup.diffuse_gain = 16'($urandom);
          setup.ambient_level = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(16385, 32767))
                                                             : 15'($urandom_range(0, 16384));
        end
      endcase
      drain();
      write_lighting(setup);
      idling = (p % 3 != 0);
      repeat (SETUP_VERTICES) send_vertex(random_vertex());
    end

    drain();
    repeat (RECIP_STEPS + 8) @(posedge clk);
    $display("Lit %0d vertices under reset lighting and %0d written setups;", lit_count, N_SETUPS);
    $display("%0d depths saturated, %0d field mismatches.", saturated_count, mismatches);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin : result_side
    int stall;
    int taken;
    taken = 0;
    result.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (taken == HOLD_AT)
        stall = HOLD_CYCLES;  // long back-pressure: pipeline fills, input stalls
      else
        stall = idling ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if ((vertex.valid && vertex.ready) || (result.valid && result.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/vll_pkg.sv
hw/rtl/vll_if.sv
hw/rtl/vll_light.sv
hw/rtl/vll_recip.sv
hw/rtl/vertex_lambert_light.sv
tb/vertex_lambert_light_checker.sv
tb/vertex_lambert_light_tb.sv
